>>> rtl/bccs_pkg.sv
// Package for the beat colour cycle sequencer.
// Holds sizes, op and register codes, and the word and table entry types.
// No dependencies; every other file in rtl imports it.
package bccs_pkg;

    // Table sizing
    localparam int MAX_ENTRIES = 16;
    localparam int TBL_AW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = 5;
    localparam int LIVE_W      = ($clog2(MAX_ENTRIES + 1) > CNT_W) ?
                                 $clog2(MAX_ENTRIES + 1) : CNT_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_POWER_ON    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEAT_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_COLOUR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DECAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 3'd4;

    // Input word op codes
    localparam logic [1:0] OP_AUDIO   = 2'd0;
    localparam logic [1:0] OP_REFRESH = 2'd1;
    localparam logic [1:0] OP_LOAD    = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic        beat;
        logic [31:0] now_ms;
        logic [3:0]  entry_index;
        logic [23:0] entry_colour;
        logic [31:0] entry_duration;
        logic        entry_by_beats;
        logic [15:0] entry_decay;
    } in_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       lit;
    } out_word_t;

    typedef struct packed {
        logic [23:0] colour;
        logic [31:0] duration;
        logic        by_beats;
        logic [15:0] decay;
    } tbl_entry_t;

endpackage

>>> rtl/bccs_table.sv
// Cycle entry table of the sequencer: one write port, combinational reads.
// Reads at the current entry, at the entry to show, and the kind bit of the
// entry being entered. Depends on bccs_pkg.
module bccs_table
    import bccs_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [TBL_AW-1:0] wr_addr,
    input  tbl_entry_t        wr_entry,
    input  logic [TBL_AW-1:0] cur_addr,
    output tbl_entry_t        cur_entry,
    input  logic [TBL_AW-1:0] show_addr,
    output tbl_entry_t        show_entry,
    input  logic [TBL_AW-1:0] enter_addr,
    output logic              enter_by_beats
);

    tbl_entry_t entry_mem_reg [MAX_ENTRIES];

    // Write one slot per load word; contents are undefined until loaded
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem_reg[wr_addr] <= wr_entry;
        end
    end

    // Read ports
    assign cur_entry      = entry_mem_reg[cur_addr];
    assign show_entry     = entry_mem_reg[show_addr];
    assign enter_by_beats = entry_mem_reg[enter_addr].by_beats;

endmodule

>>> rtl/beat_colour_cycle_sequencer_unit.sv
// Top level of the beat colour cycle sequencer.
// Input register, single-pass step logic, result register. Uses bccs_pkg
// and bccs_table.
//
//   port group   direction  handshake          payload
//   s_*          in         s_valid/s_ready    s_data  (in_word_t)
//   m_*          out        m_valid/m_ready    m_data  (out_word_t)
//   cfg_*        in         cfg_wr_en only     cfg_index, cfg_wdata
//
// One word per cycle while s_ready is high: a word is held in the input
// register, then the step logic updates the sequencer state and loads the
// result register if the word emits (an audio beat or refresh word with power
// on and beat mode set); m_valid is driven from that result register.
// A full result register holds the step stage; s_ready drops only when both
// the input register and an untaken result are full.
// Reset (aresetn, synchronous) clears control state and configuration; data
// registers and table slots stay undefined until loaded.
module beat_colour_cycle_sequencer_unit
    import bccs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers
    logic              power_on_reg;
    logic              beat_mode_reg;
    logic [23:0]       base_colour_reg;
    logic [15:0]       base_decay_reg;
    logic [CNT_W-1:0]  entry_count_reg;

    // Pipeline registers
    logic              in_vld_reg;
    in_word_t          in_word_reg;
    logic              m_vld_reg, m_vld_next;
    out_word_t         m_word_reg, m_word_next;

    // Sequencer state
    logic [TBL_AW-1:0] cur_entry_reg, cur_entry_next;
    logic [31:0]       progress_reg, progress_next;
    logic [31:0]       last_pulse_reg, last_pulse_next;

    // Step logic signals
    logic              fire;
    logic              is_audio, is_refresh, is_load, is_restart, audio_beat;
    logic [LIVE_W-1:0] live;
    logic [LIVE_W-1:0] cur_ext, nx_ext;
    logic              cur_ok;
    logic [TBL_AW-1:0] nx_idx;
    logic [31:0]       beats_plus;
    logic [31:0]       elapsed;
    logic              go;
    logic [TBL_AW-1:0] enter_addr;
    logic              enter_by_beats;
    logic [31:0]       enter_prog;
    logic [TBL_AW-1:0] show_addr;
    logic              show_ok;
    logic [23:0]       colour;
    logic [15:0]       decay;
    logic              lit;
    logic              emit;
    logic              load_ok;
    logic              tbl_we;
    tbl_entry_t        wr_entry;
    tbl_entry_t        cur_entry;
    tbl_entry_t        show_entry;

    // Step stage moves when the result register can take a word
    assign fire    = in_vld_reg && (!m_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || !m_vld_reg || m_ready;
    assign m_valid = m_vld_reg;
    assign m_data  = m_word_reg;

    // Capture input word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_on_reg    <= 1'b0;
            beat_mode_reg   <= 1'b0;
            base_colour_reg <= '0;
            base_decay_reg  <= '0;
            entry_count_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_POWER_ON:    power_on_reg    <= cfg_wdata[0];
                REG_BEAT_MODE:   beat_mode_reg   <= cfg_wdata[0];
                REG_BASE_COLOUR: base_colour_reg <= cfg_wdata[23:0];
                REG_BASE_DECAY:  base_decay_reg  <= cfg_wdata[15:0];
                REG_ENTRY_COUNT: entry_count_reg <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Decode the op
    assign is_audio   = (in_word_reg.op == OP_AUDIO);
    assign is_refresh = (in_word_reg.op == OP_REFRESH);
    assign is_load    = (in_word_reg.op == OP_LOAD);
    assign is_restart = (in_word_reg.op == OP_RESTART);
    assign audio_beat = is_audio && in_word_reg.beat;

    // Clamp the entry count to the table depth
    assign live = (LIVE_W'(entry_count_reg) > LIVE_W'(MAX_ENTRIES)) ?
                  LIVE_W'(MAX_ENTRIES) : LIVE_W'(entry_count_reg);

    // Current entry range check and wrapped successor
    assign cur_ext = LIVE_W'(cur_entry_reg);
    assign cur_ok  = cur_ext < live;
    assign nx_ext  = cur_ext + LIVE_W'(1);
    assign nx_idx  = (nx_ext >= live) ? '0 : TBL_AW'(nx_ext);

    // Advance test: beat count past duration, or elapsed time past duration
    assign beats_plus = progress_reg + 32'd1;
    assign elapsed    = in_word_reg.now_ms - progress_reg;

    always_comb begin
        if (!cur_ok || !is_audio) begin
            go = 1'b0;
        end else if (cur_entry.by_beats) begin
            go = in_word_reg.beat && (beats_plus > cur_entry.duration);
        end else begin
            go = elapsed > cur_entry.duration;
        end
    end

    // Entering an entry seeds the progress with one beat or the current time
    assign enter_addr = is_restart ? '0 : nx_idx;
    assign enter_prog = enter_by_beats ? 32'd1 : in_word_reg.now_ms;

    // Table write from load words
    assign load_ok  = ({28'd0, in_word_reg.entry_index} < 32'(MAX_ENTRIES));
    assign tbl_we   = fire && is_load && load_ok;
    assign wr_entry = '{colour:   in_word_reg.entry_colour,
                        duration: in_word_reg.entry_duration,
                        by_beats: in_word_reg.entry_by_beats,
                        decay:    in_word_reg.entry_decay};

    bccs_table u_table (
        .aclk           (aclk),
        .wr_en          (tbl_we),
        .wr_addr        (TBL_AW'(in_word_reg.entry_index)),
        .wr_entry       (wr_entry),
        .cur_addr       (cur_entry_reg),
        .cur_entry      (cur_entry),
        .show_addr      (show_addr),
        .show_entry     (show_entry),
        .enter_addr     (enter_addr),
        .enter_by_beats (enter_by_beats)
    );

    // Next sequencer state
    always_comb begin
        cur_entry_next  = cur_entry_reg;
        progress_next   = progress_reg;
        last_pulse_next = last_pulse_reg;
        if (fire) begin
            case (in_word_reg.op)
                OP_AUDIO: begin
                    if (go) begin
                        cur_entry_next = nx_idx;
                        progress_next  = enter_prog;
                    end else if (cur_ok && cur_entry.by_beats && in_word_reg.beat) begin
                        progress_next = beats_plus;
                    end
                    if (in_word_reg.beat) begin
                        last_pulse_next = in_word_reg.now_ms;
                    end
                end
                OP_RESTART: begin
                    cur_entry_next = '0;
                    if (live != '0) begin
                        progress_next = enter_prog;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_entry_reg  <= '0;
            progress_reg   <= '0;
            last_pulse_reg <= '0;
        end else begin
            cur_entry_reg  <= cur_entry_next;
            progress_reg   <= progress_next;
            last_pulse_reg <= last_pulse_next;
        end
    end

    // Colour to show: the entry after any advance, or the base when the current entry is past the live count
    assign show_addr = go ? nx_idx : cur_entry_reg;
    assign show_ok   = go || cur_ok;
    assign colour    = show_ok ? show_entry.colour : base_colour_reg;
    assign decay     = show_ok ? show_entry.decay  : base_decay_reg;

    // A beat resets the pulse time, so it is always inside the window
    assign lit  = audio_beat ||
                  ((in_word_reg.now_ms - last_pulse_reg) <= {16'd0, decay});
    assign emit = fire && power_on_reg && beat_mode_reg && (audio_beat || is_refresh);

    // Result register: load on emit, drop when taken
    always_comb begin
        m_vld_next  = m_vld_reg;
        m_word_next = m_word_reg;
        if (emit) begin
            m_vld_next        = 1'b1;
            m_word_next.red   = lit ? colour[23:16] : 8'd0;
            m_word_next.green = lit ? colour[15:8]  : 8'd0;
            m_word_next.blue  = lit ? colour[7:0]   : 8'd0;
            m_word_next.lit   = lit;
        end else if (m_ready) begin
            m_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else begin
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
    end

endmodule
